@@ hdl/ber_packet_layout_and_check_top_macros.svh @@
// Assertion macros used by the port-level checker of the bit error rate tester.
`ifndef BER_PACKET_LAYOUT_AND_CHECK_TOP_MACROS_SVH
`define BER_PACKET_LAYOUT_AND_CHECK_TOP_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define BPLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent, disabled while reset is asserted.
`define BPLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bplc_pkg.sv @@
// Constants, widths, codes and helper functions of the bit error rate tester.
package bplc_pkg;

    localparam int MAX_PACKETS = 256;
    localparam int CNT_W       = $clog2(MAX_PACKETS + 2);
    localparam int IDX_W       = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int BUF_W    = 21;
    localparam int PLEN_W   = 17;
    localparam int HDR_W    = 8;
    localparam int BITS_W   = 24;
    localparam int POP_W    = 4;

    localparam logic [BUF_W-1:0] BUF_SIZE_RESET = BUF_W'(4096);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LAYOUT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd2;

    function automatic logic [PLEN_W-1:0] pad4(input logic [SIZE_W-1:0] n);
        logic [PLEN_W-1:0] sum;
        sum = {1'b0, n} + PLEN_W'(3);
        return {sum[PLEN_W-1:2], 2'b00};
    endfunction

    function automatic logic [POP_W-1:0] ones8(input logic [BYTE_W-1:0] v);
        logic [POP_W-1:0] c;
        c = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c + POP_W'(v[k]);
        end
        return c;
    endfunction

endpackage

@@ hdl/bplc_if.sv @@
// Command and result channel interfaces of the bit error rate tester.
interface bplc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bplc_pkg::FUNC_W-1:0]   func;
    logic [bplc_pkg::SIZE_W-1:0]   packet_size;
    logic [bplc_pkg::BYTE_W-1:0]   ref_byte;
    logic [bplc_pkg::BYTE_W-1:0]   new_byte;

    modport source (output valid, func, packet_size, ref_byte, new_byte, input ready);
    modport sink   (input valid, func, packet_size, ref_byte, new_byte, output ready);
endinterface

interface bplc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [bplc_pkg::BUF_W-1:0]    packet_offset;
    logic [bplc_pkg::HDR_W-1:0]    header_byte;
    logic [bplc_pkg::PLEN_W-1:0]   padded_length;
    logic                          fill_done;
    logic                          counted;
    logic [bplc_pkg::BUF_W-1:0]    bad_bytes;
    logic [bplc_pkg::BITS_W-1:0]   bad_bits;
    logic [bplc_pkg::BUF_W-1:0]    good_bytes;

    modport source (output valid, accepted, packet_offset, header_byte, padded_length,
                    fill_done, counted, bad_bytes, bad_bits, good_bytes, input ready);
    modport sink   (input valid, accepted, packet_offset, header_byte, padded_length,
                    fill_done, counted, bad_bytes, bad_bits, good_bytes, output ready);
endinterface

@@ hdl/bplc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bplc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/ber_packet_layout_and_check_top.sv @@
// Top level of the bit error rate tester: packet layout and byte compare.
//
// Command words arrive on cmd (valid/ready) and each yields exactly one result
// word on res. A clear, a layout or an unused function code is worked out in
// the cycle it is accepted and its result word is valid in the next cycle. A
// compare reads the packet size table, a synchronous RAM, so it passes through
// S_CMP for the registered read before its result word is registered, and the
// next command is taken no earlier than the edge at which that result can first
// be taken: layout runs at one word per cycle while the receiver keeps up, and
// a compare takes no new command until its result word is registered.
// The result sits in an output register; cmd stays ready while a finished
// result waits, provided the receiver takes it in the same cycle. A stalled
// receiver holds the result and blocks further commands.
// Reset loads a buffer size of 4096 bytes and clears the layout and every
// counter; the size table holds nothing until packets are laid out, and no
// clearing pass is needed. A write on cfg_we takes effect at the next clear.
module ber_packet_layout_and_check_top (
    input  logic                          clk,
    input  logic                          rst_n,
    bplc_cmd_if.sink                      cmd,
    bplc_res_if.source                    res,
    input  logic                          cfg_we,
    input  logic [bplc_pkg::BUF_W-1:0]    cfg_wdata
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_CMP
    } state_t;

    state_t                              state_reg, state_next;
    logic [bplc_pkg::BUF_W-1:0]          buf_size_reg;
    logic [bplc_pkg::BUF_W-1:0]          free_space_reg, free_space_next;
    logic [bplc_pkg::BUF_W-1:0]          next_offset_reg, next_offset_next;
    logic [bplc_pkg::CNT_W-1:0]          pkt_count_reg, pkt_count_next;
    logic                                stopped_reg, stopped_next;
    logic [bplc_pkg::CNT_W-1:0]          cmp_index_reg, cmp_index_next;
    logic [bplc_pkg::PLEN_W-1:0]         cmp_pos_reg, cmp_pos_next;
    logic [bplc_pkg::BUF_W-1:0]          bad_bytes_reg, bad_bytes_next;
    logic [bplc_pkg::BITS_W-1:0]         bad_bits_reg, bad_bits_next;
    logic [bplc_pkg::BUF_W-1:0]          good_bytes_reg, good_bytes_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                out_acc_reg, out_acc_next;
    logic [bplc_pkg::BUF_W-1:0]          out_off_reg, out_off_next;
    logic [bplc_pkg::HDR_W-1:0]          out_hdr_reg, out_hdr_next;
    logic [bplc_pkg::PLEN_W-1:0]         out_plen_reg, out_plen_next;
    logic                                out_done_reg, out_done_next;
    logic                                out_cnt_reg, out_cnt_next;
    logic [bplc_pkg::BUF_W-1:0]          out_bbytes_reg, out_bbytes_next;
    logic [bplc_pkg::BITS_W-1:0]         out_bbits_reg, out_bbits_next;
    logic [bplc_pkg::BUF_W-1:0]          out_gbytes_reg, out_gbytes_next;

    logic                                ram_we;
    logic [bplc_pkg::SIZE_W-1:0]         ram_rdata;

    logic                                out_free;
    logic                                cmd_fire;
    logic [bplc_pkg::PLEN_W-1:0]         pad_in;
    logic [bplc_pkg::PLEN_W-1:0]         pad_tab;
    logic [bplc_pkg::PLEN_W-1:0]         pos_inc;
    logic [bplc_pkg::CNT_W-1:0]          cnt_limit;
    logic [bplc_pkg::BYTE_W-1:0]         diff;
    logic [bplc_pkg::BUF_W-1:0]          free_after;

    assign out_free = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign cmd_fire = cmd.valid && cmd.ready;

    assign pad_in     = bplc_pkg::pad4(cmd.packet_size);
    assign pad_tab    = bplc_pkg::pad4(ram_rdata);
    assign pos_inc    = cmp_pos_reg + bplc_pkg::PLEN_W'(1);
    assign cnt_limit  = (pkt_count_reg < bplc_pkg::CNT_W'(bplc_pkg::MAX_PACKETS))
                        ? pkt_count_reg : bplc_pkg::CNT_W'(bplc_pkg::MAX_PACKETS);
    assign diff       = cmd.ref_byte ^ cmd.new_byte;
    assign free_after = free_space_reg - bplc_pkg::BUF_W'(pad_in);

    assign res.valid         = out_valid_reg;
    assign res.accepted      = out_acc_reg;
    assign res.packet_offset = out_off_reg;
    assign res.header_byte   = out_hdr_reg;
    assign res.padded_length = out_plen_reg;
    assign res.fill_done     = out_done_reg;
    assign res.counted       = out_cnt_reg;
    assign res.bad_bytes     = out_bbytes_reg;
    assign res.bad_bits      = out_bbits_reg;
    assign res.good_bytes    = out_gbytes_reg;

    // The compare bytes need not stay on cmd once the word is accepted, so
    // their difference is captured at acceptance for use after the table read.
    logic [bplc_pkg::BYTE_W-1:0]         cmp_diff_reg;
    logic [bplc_pkg::POP_W-1:0]          cmp_pop;
    logic [bplc_pkg::BITS_W:0]           cmp_bits_sum;

    assign cmp_pop      = bplc_pkg::ones8(cmp_diff_reg);
    assign cmp_bits_sum = {1'b0, bad_bits_reg} + (bplc_pkg::BITS_W + 1)'(cmp_pop);

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmp_diff_reg <= diff;
        end
    end

    bplc_ram #(
        .WIDTH (bplc_pkg::SIZE_W),
        .DEPTH (bplc_pkg::MAX_PACKETS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pkt_count_reg[bplc_pkg::IDX_W-1:0]),
        .wdata (cmd.packet_size),
        .raddr (cmp_index_reg[bplc_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        free_space_next  = free_space_reg;
        next_offset_next = next_offset_reg;
        pkt_count_next   = pkt_count_reg;
        stopped_next     = stopped_reg;
        cmp_index_next   = cmp_index_reg;
        cmp_pos_next     = cmp_pos_reg;
        bad_bytes_next   = bad_bytes_reg;
        bad_bits_next    = bad_bits_reg;
        good_bytes_next  = good_bytes_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_acc_next     = out_acc_reg;
        out_off_next     = out_off_reg;
        out_hdr_next     = out_hdr_reg;
        out_plen_next    = out_plen_reg;
        out_done_next    = out_done_reg;
        out_cnt_next     = out_cnt_reg;
        out_bbytes_next  = out_bbytes_reg;
        out_bbits_next   = out_bbits_reg;
        out_gbytes_next  = out_gbytes_reg;
        ram_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                    out_off_next   = '0;
                    out_hdr_next   = '0;
                    out_plen_next  = '0;
                    out_cnt_next   = 1'b0;
                    case (cmd.func)
                        bplc_pkg::FUNC_CLEAR:
                        begin
                            free_space_next  = buf_size_reg;
                            next_offset_next = '0;
                            pkt_count_next   = '0;
                            stopped_next     = 1'b0;
                            cmp_index_next   = '0;
                            cmp_pos_next     = '0;
                            bad_bytes_next   = '0;
                            bad_bits_next    = '0;
                            good_bytes_next  = '0;
                        end
                        bplc_pkg::FUNC_LAYOUT:
                        begin
                            if (!stopped_reg)
                            begin
                                if ((cmd.packet_size == '0)
                                    || (bplc_pkg::BUF_W'(pad_in) > free_space_reg))
                                begin
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    ram_we = pkt_count_reg
                                             < bplc_pkg::CNT_W'(bplc_pkg::MAX_PACKETS);
                                    out_acc_next     = 1'b1;
                                    out_off_next     = next_offset_reg;
                                    out_hdr_next     = bplc_pkg::HDR_W'(pkt_count_reg);
                                    out_plen_next    = pad_in;
                                    pkt_count_next   = pkt_count_reg + bplc_pkg::CNT_W'(1);
                                    next_offset_next = next_offset_reg
                                                       + bplc_pkg::BUF_W'(pad_in);
                                    free_space_next  = free_after;
                                    if ((free_after == '0)
                                        || (pkt_count_reg
                                            >= bplc_pkg::CNT_W'(bplc_pkg::MAX_PACKETS)))
                                    begin
                                        stopped_next = 1'b1;
                                    end
                                end
                            end
                        end
                        bplc_pkg::FUNC_COMPARE:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_CMP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                    out_off_next   = '0;
                    out_hdr_next   = '0;
                    out_plen_next  = '0;
                    out_cnt_next   = 1'b0;
                    if (cmp_index_reg < cnt_limit)
                    begin
                        if (cmp_pos_reg < bplc_pkg::PLEN_W'(ram_rdata))
                        begin
                            out_cnt_next = 1'b1;
                            if (cmp_diff_reg != '0)
                            begin
                                if (bad_bytes_reg != '1)
                                begin
                                    bad_bytes_next = bad_bytes_reg + bplc_pkg::BUF_W'(1);
                                end
                                bad_bits_next = cmp_bits_sum[bplc_pkg::BITS_W]
                                                ? '1 : cmp_bits_sum[bplc_pkg::BITS_W-1:0];
                            end
                            else if (good_bytes_reg != '1)
                            begin
                                good_bytes_next = good_bytes_reg + bplc_pkg::BUF_W'(1);
                            end
                        end
                        if (pos_inc >= pad_tab)
                        begin
                            cmp_pos_next   = '0;
                            cmp_index_next = cmp_index_reg + bplc_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            cmp_pos_next = pos_inc;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_valid_next && !(out_valid_reg && !res.ready))
        begin
            out_done_next   = stopped_next;
            out_bbytes_next = bad_bytes_next;
            out_bbits_next  = bad_bits_next;
            out_gbytes_next = good_bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            buf_size_reg    <= bplc_pkg::BUF_SIZE_RESET;
            free_space_reg  <= bplc_pkg::BUF_SIZE_RESET;
            next_offset_reg <= '0;
            pkt_count_reg   <= '0;
            stopped_reg     <= 1'b0;
            cmp_index_reg   <= '0;
            cmp_pos_reg     <= '0;
            bad_bytes_reg   <= '0;
            bad_bits_reg    <= '0;
            good_bytes_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_acc_reg     <= 1'b0;
            out_off_reg     <= '0;
            out_hdr_reg     <= '0;
            out_plen_reg    <= '0;
            out_done_reg    <= 1'b0;
            out_cnt_reg     <= 1'b0;
            out_bbytes_reg  <= '0;
            out_bbits_reg   <= '0;
            out_gbytes_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                buf_size_reg <= cfg_wdata;
            end
            free_space_reg  <= free_space_next;
            next_offset_reg <= next_offset_next;
            pkt_count_reg   <= pkt_count_next;
            stopped_reg     <= stopped_next;
            cmp_index_reg   <= cmp_index_next;
            cmp_pos_reg     <= cmp_pos_next;
            bad_bytes_reg   <= bad_bytes_next;
            bad_bits_reg    <= bad_bits_next;
            good_bytes_reg  <= good_bytes_next;
            out_valid_reg   <= out_valid_next;
            out_acc_reg     <= out_acc_next;
            out_off_reg     <= out_off_next;
            out_hdr_reg     <= out_hdr_next;
            out_plen_reg    <= out_plen_next;
            out_done_reg    <= out_done_next;
            out_cnt_reg     <= out_cnt_next;
            out_bbytes_reg  <= out_bbytes_next;
            out_bbits_reg   <= out_bbits_next;
            out_gbytes_reg  <= out_gbytes_next;
        end
    end

endmodule

@@ hdl/bplc_checker.sv @@
// Port-level checker of the bit error rate tester, bound to its top level.
`include "ber_packet_layout_and_check_top_macros.svh"

module bplc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          res_accepted,
    input logic [bplc_pkg::BUF_W-1:0]    res_packet_offset,
    input logic [bplc_pkg::HDR_W-1:0]    res_header_byte,
    input logic [bplc_pkg::PLEN_W-1:0]   res_padded_length,
    input logic                          res_counted
);

    `BPLC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_packet_offset) && $stable(res_padded_length), "result word changed while stalled")
    `BPLC_ASSERT_SAME(a_pad_word, clk, rst_n, res_valid && res_accepted, (res_padded_length != '0) && (res_padded_length[1:0] == 2'b00), "placed packet has a bad padded length")
    `BPLC_ASSERT_SAME(a_reject_zero, clk, rst_n, res_valid && !res_accepted, (res_packet_offset == '0) && (res_header_byte == '0) && (res_padded_length == '0), "layout fields set without a placed packet")
    `BPLC_ASSERT_SAME(a_one_kind, clk, rst_n, res_valid && res_counted, !res_accepted, "word reports both a placement and a compared byte")

endmodule

bind ber_packet_layout_and_check_top bplc_checker u_bplc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_accepted      (res.accepted),
    .res_packet_offset (res.packet_offset),
    .res_header_byte   (res.header_byte),
    .res_padded_length (res.padded_length),
    .res_counted       (res.counted)
);

@@ tb/sv/bplc_layout_compare_checker.sv @@
// Checker for the bit error rate tester: predicts each result word and compares it.
`timescale 1ns / 100ps

module bplc_layout_compare_checker
    import bplc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bplc_cmd_if              cmd,
    bplc_res_if              res,
    input  logic             cfg_we,
    input  logic [BUF_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic              accepted;
        logic [BUF_W-1:0]  packet_offset;
        logic [HDR_W-1:0]  header_byte;
        logic [PLEN_W-1:0] padded_length;
        logic              fill_done;
        logic              counted;
        logic [BUF_W-1:0]  bad_bytes;
        logic [BITS_W-1:0] bad_bits;
        logic [BUF_W-1:0]  good_bytes;
    } result_word_t;

    localparam logic [BUF_W-1:0]  BYTE_COUNT_MAX = '1;
    localparam logic [BITS_W-1:0] BIT_COUNT_MAX  = '1;

    result_word_t      expected_words[$];

    logic [BUF_W-1:0]  buffer_bytes;
    logic [BUF_W-1:0]  free_bytes;
    logic [BUF_W-1:0]  next_offset;
    logic [CNT_W-1:0]  placed_count;
    logic              fill_stopped;
    logic [SIZE_W-1:0] packet_sizes [MAX_PACKETS];
    logic [CNT_W-1:0]  walk_index;
    logic [PLEN_W-1:0] walk_position;
    logic [BUF_W-1:0]  bad_byte_total;
    logic [BITS_W-1:0] bad_bit_total;
    logic [BUF_W-1:0]  good_byte_total;

    function automatic logic [PLEN_W-1:0] word_padded(input logic [SIZE_W-1:0] size);
        logic [PLEN_W-1:0] sum;
        sum = PLEN_W'(size) + PLEN_W'(3);
        sum[1:0] = 2'b00;
        return sum;
    endfunction

    task automatic clear_layout();
        free_bytes      = buffer_bytes;
        next_offset     = '0;
        placed_count    = '0;
        fill_stopped    = 1'b0;
        walk_index      = '0;
        walk_position   = '0;
        bad_byte_total  = '0;
        bad_bit_total   = '0;
        good_byte_total = '0;
    endtask

    task automatic apply_command(input logic [FUNC_W-1:0] func,
                                 input logic [SIZE_W-1:0] size,
                                 input logic [BYTE_W-1:0] ref_byte,
                                 input logic [BYTE_W-1:0] new_byte,
                                 output result_word_t     word);
        logic [PLEN_W-1:0] padded;
        logic [SIZE_W-1:0] stored_size;
        logic [BYTE_W-1:0] diff;
        int                bit_total;
        word = '0;
        case (func)
            FUNC_CLEAR:
            begin
                clear_layout();
            end
            FUNC_LAYOUT:
            begin
                if (!fill_stopped)
                begin
                    padded = word_padded(size);
                    if (size == '0 || BUF_W'(padded) > free_bytes)
                    begin
                        fill_stopped = 1'b1;
                    end
                    else
                    begin
                        if (placed_count < CNT_W'(MAX_PACKETS))
                        begin
                            packet_sizes[placed_count[IDX_W-1:0]] = size;
                        end
                        word.accepted      = 1'b1;
                        word.packet_offset = next_offset;
                        word.header_byte   = placed_count[HDR_W-1:0];
                        word.padded_length = padded;
                        placed_count       = placed_count + 1'b1;
                        next_offset        = next_offset + BUF_W'(padded);
                        free_bytes         = free_bytes - BUF_W'(padded);
                        if (free_bytes == '0 || placed_count > CNT_W'(MAX_PACKETS))
                        begin
                            fill_stopped = 1'b1;
                        end
                    end
                end
            end
            FUNC_COMPARE:
            begin
                if (walk_index < placed_count && walk_index < CNT_W'(MAX_PACKETS))
                begin
                    stored_size = packet_sizes[walk_index[IDX_W-1:0]];
                    padded      = word_padded(stored_size);
                    if (walk_position < PLEN_W'(stored_size))
                    begin
                        word.counted = 1'b1;
                        diff = ref_byte ^ new_byte;
                        if (diff != '0)
                        begin
                            if (bad_byte_total != BYTE_COUNT_MAX)
                            begin
                                bad_byte_total = bad_byte_total + 1'b1;
                            end
                            bit_total = int'(bad_bit_total) + $countones(diff);
                            if (bit_total > int'(BIT_COUNT_MAX))
                            begin
                                bit_total = int'(BIT_COUNT_MAX);
                            end
                            bad_bit_total = BITS_W'(bit_total);
                        end
                        else if (good_byte_total != BYTE_COUNT_MAX)
                        begin
                            good_byte_total = good_byte_total + 1'b1;
                        end
                    end
                    walk_position = walk_position + 1'b1;
                    if (walk_position >= padded)
                    begin
                        walk_position = '0;
                        walk_index    = walk_index + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        word.fill_done  = fill_stopped;
        word.bad_bytes  = bad_byte_total;
        word.bad_bits   = bad_bit_total;
        word.good_bytes = good_byte_total;
    endtask

    task automatic report_mismatch(input string text);
        if (mismatches < 40)
        begin
            $display("[%0t] mismatch: %s", $time, text);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        result_word_t got;
        if (!rst_n)
        begin
            mismatches   = 0;
            buffer_bytes = BUF_SIZE_RESET;
            clear_layout();
            expected_words.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                apply_command(cmd.func, cmd.packet_size, cmd.ref_byte, cmd.new_byte, want);
                expected_words.push_back(want);
            end
            if (res.valid && res.ready)
            begin
                got = '{res.accepted, res.packet_offset, res.header_byte, res.padded_length,
                        res.fill_done, res.counted, res.bad_bytes, res.bad_bits,
                        res.good_bytes};
                if (expected_words.size() == 0)
                begin
                    report_mismatch("result word arrived with no command outstanding");
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("accepted", got.accepted, want.accepted);
                    check_field("packet_offset", got.packet_offset, want.packet_offset);
                    check_field("header_byte", got.header_byte, want.header_byte);
                    check_field("padded_length", got.padded_length, want.padded_length);
                    check_field("fill_done", got.fill_done, want.fill_done);
                    check_field("counted", got.counted, want.counted);
                    check_field("bad_bytes", got.bad_bytes, want.bad_bytes);
                    check_field("bad_bits", got.bad_bits, want.bad_bits);
                    check_field("good_bytes", got.good_bytes, want.good_bytes);
                end
            end
            if (cfg_we)
            begin
                buffer_bytes = cfg_wdata;
            end
        end
        outstanding = expected_words.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the bit error rate tester testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import bplc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                WORD_TARGET = 2000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [BUF_W-1:0] cfg_wdata;
    logic             hold_request;
    int               mismatches;
    int               outstanding;
    int               idle_pct;
    int               stall_pct;
    int               words_sent;
    int               buffer_setting;

    bplc_cmd_if cmd_if();
    bplc_res_if res_if();

    ber_packet_layout_and_check_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bplc_layout_compare_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .res         (res_if),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // The receiver holds off for a long stretch once a hold is requested.
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left  = 300;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [SIZE_W-1:0] size,
                             input logic [BYTE_W-1:0] ref_byte,
                             input logic [BYTE_W-1:0] new_byte);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= func;
        cmd_if.packet_size <= size;
        cmd_if.ref_byte    <= ref_byte;
        cmd_if.new_byte    <= new_byte;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_layout(input logic [SIZE_W-1:0] size);
        send_word(FUNC_LAYOUT, size, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic send_compare(input logic [BYTE_W-1:0] ref_byte,
                                input logic [BYTE_W-1:0] new_byte);
        send_word(FUNC_COMPARE, SIZE_W'($urandom), ref_byte, new_byte);
    endtask

    task automatic send_clear();
        send_word(FUNC_CLEAR, SIZE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic send_random_compare();
        logic [BYTE_W-1:0] ref_byte;
        logic [BYTE_W-1:0] new_byte;
        int                pick;
        ref_byte = BYTE_W'($urandom);
        pick     = $urandom_range(9);
        if (pick < 5)
        begin
            new_byte = ref_byte;
        end
        else if (pick < 7)
        begin
            new_byte = ref_byte ^ (8'h01 << $urandom_range(7));
        end
        else
        begin
            new_byte = BYTE_W'($urandom);
        end
        send_compare(ref_byte, new_byte);
    endtask

    task automatic wait_until_idle();
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_buffer_size(input int bytes);
        cfg_we         <= 1'b1;
        cfg_wdata      <= BUF_W'(bytes);
        buffer_setting  = bytes;
        @(posedge clk);
        cfg_we         <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] random_packet_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            return '0;
        end
        else if (pick < 16)
        begin
            return SIZE_W'($urandom);
        end
        else if (pick < 20)
        begin
            return '1;
        end
        return SIZE_W'($urandom_range(1, 64));
    endfunction

    function automatic int random_buffer_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            return $urandom_range(0, 600);
        end
        else if (pick < 80)
        begin
            return $urandom_range(0, 1048576);
        end
        else if (pick < 90)
        begin
            return 4 * $urandom_range(1, 40);
        end
        return $urandom_range(1, 16);
    endfunction

    // Buffer size, clear, layouts, then a noisy walk over the laid-out bytes.
    task automatic run_session();
        int                layouts;
        int                bytes_laid;
        int                walk;
        int                pick;
        logic [SIZE_W-1:0] size;
        write_buffer_size(random_buffer_size());
        if ($urandom_range(4) == 0)
        begin
            send_layout(random_packet_size());
        end
        send_clear();
        layouts    = $urandom_range(1, 12);
        bytes_laid = 0;
        repeat (layouts)
        begin
            size = random_packet_size();
            bytes_laid += ((int'(size) + 3) / 4) * 4;
            send_layout(size);
        end
        walk = bytes_laid;
        if (walk > buffer_setting)
        begin
            walk = buffer_setting;
        end
        if (walk > 400)
        begin
            walk = 400;
        end
        walk += $urandom_range(0, 4);
        repeat (walk)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                send_word(FUNC_UNUSED, SIZE_W'($urandom), BYTE_W'($urandom),
                          BYTE_W'($urandom));
            end
            else if (pick < 5)
            begin
                send_layout(SIZE_W'($urandom_range(1, 16)));
            end
            else if (pick == 5)
            begin
                send_clear();
            end
            else
            begin
                send_random_compare();
            end
        end
        wait_until_idle();
    endtask

    initial
    begin
        int i;
        int session;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        hold_request       <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.func        <= FUNC_CLEAR;
        cmd_if.packet_size <= '0;
        cmd_if.ref_byte    <= '0;
        cmd_if.new_byte    <= '0;
        idle_pct       = 0;
        stall_pct      = 0;
        words_sent     = 0;
        buffer_setting = 4096;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words on the reset buffer size of 4096 bytes.
        send_compare(8'hFF, 8'h00);
        send_word(FUNC_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
        send_layout(16'd1);
        send_layout(16'd4);
        send_layout(16'd5);
        for (i = 0; i < 17; i++)
        begin
            send_compare(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : (i[2] ? 8'hAA : 8'h00));
        end
        send_layout(16'd0);
        send_layout(16'd8);
        send_clear();
        send_layout(16'hFFFF);
        send_compare(8'h00, 8'hFF);
        wait_until_idle();

        // A buffer of 1048576 bytes fills exactly with the largest packets.
        write_buffer_size(1048576);
        send_clear();
        repeat (16) send_layout(16'hFFFF);
        send_layout(16'd1);
        repeat (8) send_random_compare();
        wait_until_idle();

        // An empty buffer takes nothing.
        write_buffer_size(0);
        send_clear();
        send_layout(16'd4);
        send_compare(8'h0F, 8'hF0);
        send_clear();
        wait_until_idle();

        // Fill the packet tables past their end, with a long receiver hold-off.
        write_buffer_size(4096);
        idle_pct = 45;
        send_clear();
        for (i = 0; i < 258; i++)
        begin
            if (i == 20)
            begin
                hold_request <= 1'b1;
            end
            send_layout(SIZE_W'($urandom_range(1, 4)));
        end
        repeat (MAX_PACKETS * 4 + 4) send_random_compare();
        wait_until_idle();

        session = 0;
        while (words_sent < WORD_TARGET)
        begin
            case (session % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            run_session();
            session++;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bplc_pkg.sv
hdl/bplc_if.sv
hdl/bplc_ram.sv
hdl/ber_packet_layout_and_check_top.sv
hdl/bplc_checker.sv
tb/sv/bplc_layout_compare_checker.sv
tb/sv/testbench.sv
